@@ rtl/utf8vd_pkg.sv @@
// Shared types, status codes and byte-class functions for the UTF-8 validating decoder.
// Depends on nothing; the decode step, the top level and the checker use it.
package utf8vd_pkg;

    localparam int DATA_W     = 8;
    localparam int CODE_W     = 21;
    localparam int M_TDATA_W  = 40;   // 21 + 8 + 8 bits, padded to whole bytes
    localparam int M_TUSER_W  = 2;

    // Lead byte constants: invalid leads C0, C1, F5 and leads whose first continuation has a narrowed range
    localparam logic [DATA_W-1:0] LEAD_C0 = 8'hC0;
    localparam logic [DATA_W-1:0] LEAD_C1 = 8'hC1;
    localparam logic [DATA_W-1:0] LEAD_E0 = 8'hE0;
    localparam logic [DATA_W-1:0] LEAD_ED = 8'hED;
    localparam logic [DATA_W-1:0] LEAD_F0 = 8'hF0;
    localparam logic [DATA_W-1:0] LEAD_F4 = 8'hF4;
    localparam logic [DATA_W-1:0] LEAD_F5 = 8'hF5;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_BAD_LEAD   = 2'd1,
        ST_BAD_CONT   = 2'd2,
        ST_INCOMPLETE = 2'd3
    } t_status;

    // One result item
    typedef struct packed {
        logic [CODE_W-1:0] code_point;
        t_status           status;
        logic [DATA_W-1:0] lead_seen;
        logic [DATA_W-1:0] offending_byte;
        logic              last_of_run;
    } t_result;

    // Open-sequence state
    typedef struct packed {
        logic [DATA_W-1:0] lead_byte;
        logic [1:0]        bytes_owed;
        logic [CODE_W-1:0] partial_code;
        logic              first_cont_pending;
    } t_seq;

    // Outcome of handling a byte as a lead while idle
    typedef struct packed {
        logic    opens;   // sequence opened, no result
        t_result res;
        t_seq    seq;
    } t_lead;

    // Continuation bytes a lead asks for; 0 for an invalid lead
    function automatic logic [1:0] lead_need(input logic [DATA_W-1:0] b);
        logic [1:0] need;
        need = 2'd0;
        priority if (b[7:6] == 2'b10) begin
            need = 2'd0;
        end else if (b[7:5] == 3'b110) begin
            need = (b == LEAD_C0 || b == LEAD_C1) ? 2'd0 : 2'd1;
        end else if (b[7:4] == 4'b1110) begin
            need = 2'd2;
        end else if (b[7:2] == 6'b111100 || b == LEAD_F4) begin
            need = 2'd3;
        end else begin
            need = 2'd0;
        end
        return need;
    endfunction

    // Payload bits carried by a multi-byte lead
    function automatic logic [CODE_W-1:0] lead_bits(input logic [DATA_W-1:0] b,
                                                    input logic [1:0]        need);
        logic [CODE_W-1:0] bits;
        unique case (need)
            2'd1:    bits = {16'd0, b[4:0]};
            2'd2:    bits = {17'd0, b[3:0]};
            default: bits = {18'd0, b[2:0]};
        endcase
        return bits;
    endfunction

    // Continuation check against the well-formed table
    function automatic logic cont_ok(input t_seq s, input logic [DATA_W-1:0] c);
        logic ok;
        ok = (c[7:6] == 2'b10);
        if (s.first_cont_pending) begin
            unique case (s.lead_byte)
                LEAD_E0: ok = (c[7:5] == 3'b101);
                LEAD_ED: ok = (c[7:5] == 3'b100);
                LEAD_F0: ok = (c[7:5] == 3'b101) || (c[7:4] == 4'b1001);
                LEAD_F4: ok = (c[7:4] == 4'b1000);
                default: ok = (c[7:6] == 2'b10);
            endcase
        end
        return ok;
    endfunction

    // Handle a byte as a lead from the idle state
    function automatic t_lead take_lead(input logic [DATA_W-1:0] b, input logic eot);
        t_lead      l;
        logic [1:0] need;
        need                   = lead_need(b);
        l                      = '0;
        l.res.status           = ST_OK;
        l.res.lead_seen        = b;
        if (!b[7]) begin
            l.res.code_point   = {13'd0, b};
        end else if (need == 2'd0) begin
            l.res.status       = ST_BAD_LEAD;
        end else if (eot) begin
            l.res.status       = ST_INCOMPLETE;
        end else begin
            l.opens                  = 1'b1;
            l.seq.lead_byte          = b;
            l.seq.bytes_owed         = need;
            l.seq.partial_code       = lead_bits(b, need);
            l.seq.first_cont_pending = 1'b1;
        end
        return l;
    endfunction

endpackage

@@ rtl/utf8vd_step.sv @@
// Per-byte decode step: next sequence state and up to two result items.
// Depends on utf8vd_pkg (types, status codes, byte-class functions).
module utf8vd_step (
    input  logic [utf8vd_pkg::DATA_W-1:0] i_byte,
    input  logic                          i_eot,
    input  utf8vd_pkg::t_seq              i_seq,
    output utf8vd_pkg::t_seq              o_seq_next,
    output logic [1:0]                    o_count,
    output utf8vd_pkg::t_result           o_res0,
    output utf8vd_pkg::t_result           o_res1
);

    utf8vd_pkg::t_lead             lead;
    logic [utf8vd_pkg::CODE_W-1:0] acc;
    logic [1:0]                    owed;

    assign lead = utf8vd_pkg::take_lead(i_byte, i_eot);
    assign acc  = {i_seq.partial_code[utf8vd_pkg::CODE_W-7:0], i_byte[5:0]};
    assign owed = i_seq.bytes_owed - 2'd1;

    always_comb begin
        o_seq_next = i_seq;
        o_count    = 2'd0;
        o_res0     = '0;
        o_res1     = '0;
        if (i_seq.bytes_owed == 2'd0) begin
            // idle: byte is a lead
            o_seq_next         = lead.seq;
            o_count            = lead.opens ? 2'd0 : 2'd1;
            o_res0             = lead.res;
            o_res0.last_of_run = 1'b1;
        end else if (utf8vd_pkg::cont_ok(i_seq, i_byte)) begin
            // good continuation
            if (owed == 2'd0) begin
                o_res0.code_point  = acc;
                o_res0.status      = utf8vd_pkg::ST_OK;
                o_res0.lead_seen   = i_seq.lead_byte;
                o_res0.last_of_run = 1'b1;
                o_count            = 2'd1;
                o_seq_next         = '0;
            end else if (i_eot) begin
                o_res0.status      = utf8vd_pkg::ST_INCOMPLETE;
                o_res0.lead_seen   = i_seq.lead_byte;
                o_res0.last_of_run = 1'b1;
                o_count            = 2'd1;
                o_seq_next         = '0;
            end else begin
                o_seq_next.partial_code       = acc;
                o_seq_next.bytes_owed         = owed;
                o_seq_next.first_cont_pending = 1'b0;
            end
        end else begin
            // bad continuation, then the same byte again as a lead
            o_res0.status         = utf8vd_pkg::ST_BAD_CONT;
            o_res0.lead_seen      = i_seq.lead_byte;
            o_res0.offending_byte = i_byte;
            o_res0.last_of_run    = lead.opens;
            o_seq_next            = lead.seq;
            o_res1                = lead.res;
            o_res1.last_of_run    = 1'b1;
            o_count               = lead.opens ? 2'd1 : 2'd2;
        end
    end

endmodule

@@ rtl/utf8_validating_decoder.sv @@
// Top level of the streaming UTF-8 validating decoder.
// Depends on utf8vd_pkg and utf8vd_step.
//
// Usage:
//   Input stream: one raw byte per transaction on s_axis_tdata[7:0];
//   s_axis_tlast marks the last byte of a text. Output stream: one result
//   per transaction; m_axis_tuser carries the status (0 ok, 1 invalid lead,
//   2 invalid continuation, 3 incomplete), m_axis_tlast marks the final
//   result caused by one input byte.
//   A byte taken into the input register is decoded from there into the
//   output register once the output side has room for its results.
//   Throughput: one byte per cycle unless the receiver stalls or a byte gives
//   two results. The output register plus one overflow slot hold a byte's 0, 1
//   or 2 results; a byte with two holds the decode stage until the first is taken.
//   Reset (i_rst_n low, synchronous) empties the input and output stages and
//   closes any open sequence.
//   When the receiver stalls, the output register holds its transaction, the
//   input register still fills once, and s_axis_tready then drops.
module utf8_validating_decoder (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [utf8vd_pkg::DATA_W-1:0]    s_axis_tdata,  // [7:0] data_byte
    input  logic                             s_axis_tlast,  // end_of_text
    // output stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // [20:0] code_point, [28:21] lead_seen, [36:29] offending_byte, [39:37] zero
    output logic [utf8vd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    output logic [utf8vd_pkg::M_TUSER_W-1:0] m_axis_tuser,  // [1:0] status
    output logic                             m_axis_tlast   // last_of_run
);

    // input register
    logic                          r_in_valid;
    logic [utf8vd_pkg::DATA_W-1:0] r_in_byte;
    logic                          r_in_eot;

    // sequence state
    utf8vd_pkg::t_seq r_seq;
    utf8vd_pkg::t_seq n_seq;

    // output register and overflow slot
    logic                r_out_valid;
    utf8vd_pkg::t_result r_out;
    logic                r_out2_valid;
    utf8vd_pkg::t_result r_out2;

    logic [1:0]          res_count;
    utf8vd_pkg::t_result res0;
    utf8vd_pkg::t_result res1;
    logic                fire;
    logic                out_take;

    utf8vd_step u_step (
        .i_byte     (r_in_byte),
        .i_eot      (r_in_eot),
        .i_seq      (r_seq),
        .o_seq_next (n_seq),
        .o_count    (res_count),
        .o_res0     (res0),
        .o_res1     (res1)
    );

    // decode fires when the output side has room for two results
    assign out_take      = r_out_valid && m_axis_tready;
    assign fire          = r_in_valid && !r_out2_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || fire;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_byte <= s_axis_tdata;
            r_in_eot  <= s_axis_tlast;
        end
    end

    // sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else if (fire) begin
            r_seq <= n_seq;
        end
    end

    // output valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_out2_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid  <= (res_count != 2'd0);
            r_out2_valid <= (res_count == 2'd2);
        end else if (out_take) begin
            r_out_valid  <= r_out2_valid;
            r_out2_valid <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_out  <= res0;
            r_out2 <= res1;
        end else if (out_take) begin
            r_out  <= r_out2;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {3'b000, r_out.offending_byte, r_out.lead_seen, r_out.code_point};
    assign m_axis_tuser  = r_out.status;
    assign m_axis_tlast  = r_out.last_of_run;

endmodule

@@ rtl/utf8vd_checker.sv @@
// Port-level checker for the UTF-8 validating decoder, bound to the top level.
// Depends on utf8vd_pkg (status codes and lead byte constants).
module utf8vd_checker (
    input logic                             i_clk,
    input logic                             i_rst_n,
    input logic                             m_axis_tvalid,
    input logic                             m_axis_tready,
    input logic [utf8vd_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input logic [utf8vd_pkg::M_TUSER_W-1:0] m_axis_tuser,
    input logic                             m_axis_tlast
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
        && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("output transaction changed while stalled");

    // error results carry no code point
    a_err_no_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != utf8vd_pkg::ST_OK |-> m_axis_tdata[20:0] == 21'd0)
        else $error("code point set on an error result");

    // offending byte only on invalid continuation
    a_off_only_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != utf8vd_pkg::ST_BAD_CONT
        |-> m_axis_tdata[36:29] == 8'd0)
        else $error("offending byte set outside an invalid continuation");

    // invalid leads come only from continuation bytes, C0/C1 and F5..FF
    a_bad_lead_class: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == utf8vd_pkg::ST_BAD_LEAD
        |-> m_axis_tdata[28] && (m_axis_tdata[28:21] <= utf8vd_pkg::LEAD_C1
            || m_axis_tdata[28:21] >= utf8vd_pkg::LEAD_F5))
        else $error("invalid lead reported for a well-formed lead byte");

    // ok results stay inside the scalar range
    a_ok_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser == utf8vd_pkg::ST_OK
        |-> m_axis_tdata[20:0] <= 21'h10FFFF)
        else $error("decoded code point out of range");

endmodule

bind utf8_validating_decoder utf8vd_checker u_utf8vd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

@@ dv/utf8_validating_decoder_tb.sv @@
// Self-checking testbench for the streaming UTF-8 validating decoder.
// Needs utf8vd_pkg and utf8_validating_decoder. It predicts every result from its own
// model of the sequence state and checks the output stream while both sides stall at random.
module utf8_validating_decoder_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RANDOM_ITEMS = 850;
    localparam int TAIL_ITEMS   = 120;   // no idling on either side for the last bytes
    localparam int DRAIN_AT     = 325;   // byte index that waits for all results first
    localparam int STALL_LIMIT  = 400;   // cycles with no transaction before giving up
    localparam int SETTLE       = 8;     // extra cycles after the last result

    // One pending input byte
    typedef struct {
        logic [7:0] data;
        logic       eot;
        logic       wait_drain;
    } t_text_byte;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [utf8vd_pkg::DATA_W-1:0]    s_axis_tdata  = '0;  // [7:0] data_byte
    logic                             s_axis_tlast  = 1'b0; // end_of_text
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    // [20:0] code_point, [28:21] lead_seen, [36:29] offending_byte, [39:37] zero
    logic [utf8vd_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [utf8vd_pkg::M_TUSER_W-1:0] m_axis_tuser;         // [1:0] status
    logic                             m_axis_tlast;         // last_of_run

    t_text_byte          tx_bytes[$];
    utf8vd_pkg::t_result cp_expected[$];
    int unsigned results_due  = 0;
    int unsigned results_seen = 0;
    int unsigned mismatches   = 0;
    int unsigned quiet_cycles = 0;
    logic        quiet_tail   = 1'b0;

    // Predicted sequence state
    logic [7:0]  seq_lead  = '0;
    logic [1:0]  seq_owed  = '0;
    logic [20:0] seq_code  = '0;
    logic        seq_first = 1'b0;

    // Opening bytes: {end_of_text, data_byte}
    logic [8:0] opening_seq [0:24] = '{
        9'h000, 9'h07F, 9'h080, 9'h0C1, 9'h0F5,   // ASCII ends, bad leads
        9'h0C2, 9'h0A9,                           // two-byte character
        9'h0E0, 9'h0A0, 9'h080,                   // shortest three-byte after E0
        9'h0E0, 9'h09F,                           // overlong after E0
        9'h0ED, 9'h0A0,                           // surrogate after ED
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,           // highest scalar value
        9'h0F0, 9'h090, 9'h180,                   // text ends mid-sequence
        9'h1E2,                                   // lead carrying the end mark
        9'h0C3, 9'h041,                           // bad continuation that is ASCII
        9'h1FF
    };

    always #6 i_clk = ~i_clk;

    utf8_validating_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic void close_seq();
        seq_lead  = '0;
        seq_owed  = '0;
        seq_code  = '0;
        seq_first = 1'b0;
    endfunction

    // Byte taken as a lead while idle; returns 1 when it yields a result
    function automatic logic lead_outcome(input logic [7:0] b, input logic eot,
                                          output utf8vd_pkg::t_result res);
        logic [1:0] need;
        res           = '0;
        res.status    = utf8vd_pkg::ST_OK;
        res.lead_seen = b;
        if (b < 8'h80) begin
            res.code_point = {13'd0, b};
            return 1'b1;
        end
        if (b >= 8'hC2 && b <= 8'hDF)
            need = 2'd1;
        else if (b >= 8'hE0 && b <= 8'hEF)
            need = 2'd2;
        else if (b >= utf8vd_pkg::LEAD_F0 && b <= utf8vd_pkg::LEAD_F4)
            need = 2'd3;
        else
            need = 2'd0;
        if (need == 2'd0) begin
            res.status = utf8vd_pkg::ST_BAD_LEAD;
            return 1'b1;
        end
        if (eot) begin
            res.status = utf8vd_pkg::ST_INCOMPLETE;
            return 1'b1;
        end
        seq_lead  = b;
        seq_owed  = need;
        seq_first = 1'b1;
        seq_code  = (need == 2'd1) ? {16'd0, b[4:0]} :
                    (need == 2'd2) ? {17'd0, b[3:0]} : {18'd0, b[2:0]};
        return 1'b0;
    endfunction

    // Allowed continuation range; the first one after E0, ED, F0, F4 is narrowed
    function automatic logic cont_fits(input logic [7:0] c);
        logic [7:0] lo;
        logic [7:0] hi;
        lo = 8'h80;
        hi = 8'hBF;
        if (seq_first) begin
            case (seq_lead)
                utf8vd_pkg::LEAD_E0: lo = 8'hA0;
                utf8vd_pkg::LEAD_ED: hi = 8'h9F;
                utf8vd_pkg::LEAD_F0: lo = 8'h90;
                utf8vd_pkg::LEAD_F4: hi = 8'h8F;
                default: ;
            endcase
        end
        return (c >= lo) && (c <= hi);
    endfunction

    // Advance the predicted state by one accepted byte and queue its results
    function automatic void decode_expect(input logic [7:0] b, input logic eot);
        utf8vd_pkg::t_result r [2];
        int                  n;
        r[0] = '0;
        r[1] = '0;
        n    = 0;
        if (seq_owed == 2'd0) begin
            n = lead_outcome(b, eot, r[0]);
        end else if (cont_fits(b)) begin
            seq_code  = {seq_code[14:0], b[5:0]};
            seq_first = 1'b0;
            seq_owed  = seq_owed - 2'd1;
            if (seq_owed == 2'd0) begin
                r[0].code_point = seq_code;
                r[0].status     = utf8vd_pkg::ST_OK;
                r[0].lead_seen  = seq_lead;
                n = 1;
                close_seq();
            end else if (eot) begin
                r[0].status    = utf8vd_pkg::ST_INCOMPLETE;
                r[0].lead_seen = seq_lead;
                n = 1;
                close_seq();
            end
        end else begin
            // broken sequence: report it, then retry the same byte as a lead
            r[0].status         = utf8vd_pkg::ST_BAD_CONT;
            r[0].lead_seen      = seq_lead;
            r[0].offending_byte = b;
            close_seq();
            n = 1 + lead_outcome(b, eot, r[1]);
        end
        if (n > 0)
            r[n-1].last_of_run = 1'b1;
        for (int k = 0; k < n; k++)
            cp_expected.push_back(r[k]);
        results_due += n;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic void add_byte(input logic [7:0] b, input logic eot);
        t_text_byte t;
        t.data       = b;
        t.eot        = eot;
        // random drain pauses stay out of the idle-free tail
        t.wait_drain = (tx_bytes.size() == DRAIN_AT) ||
                       ((tx_bytes.size() < 25 + RANDOM_ITEMS - TAIL_ITEMS) &&
                        ($urandom_range(0, 249) == 0));
        tx_bytes.push_back(t);
    endfunction

    // Well-formed character of len bytes, byte k in bits [8k+7:8k]
    function automatic logic [31:0] make_char(input int len);
        logic [31:0] c;
        c[15:8]  = 8'h80 | 8'($urandom_range(0, 63));
        c[23:16] = 8'h80 | 8'($urandom_range(0, 63));
        c[31:24] = 8'h80 | 8'($urandom_range(0, 63));
        case (len)
            1: c[7:0] = 8'($urandom_range(0, 127));
            2: c[7:0] = 8'($urandom_range(8'hC2, 8'hDF));
            3: begin
                c[7:0] = 8'($urandom_range(8'hE0, 8'hEF));
                if (c[7:0] == utf8vd_pkg::LEAD_E0)
                    c[15:8] = 8'($urandom_range(8'hA0, 8'hBF));
                else if (c[7:0] == utf8vd_pkg::LEAD_ED)
                    c[15:8] = 8'($urandom_range(8'h80, 8'h9F));
            end
            default: begin
                c[7:0] = 8'($urandom_range(utf8vd_pkg::LEAD_F0, utf8vd_pkg::LEAD_F4));
                if (c[7:0] == utf8vd_pkg::LEAD_F0)
                    c[15:8] = 8'($urandom_range(8'h90, 8'hBF));
                else if (c[7:0] == utf8vd_pkg::LEAD_F4)
                    c[15:8] = 8'($urandom_range(8'h80, 8'h8F));
            end
        endcase
        return c;
    endfunction

    initial begin : run
        int          pick;
        int          len;
        int          keep;
        logic [31:0] chr;

        foreach (opening_seq[i])
            add_byte(opening_seq[i][7:0], opening_seq[i][8]);

        // mostly valid text, with truncated sequences, bad continuations and noise
        while (tx_bytes.size() < 25 + RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            if (pick < 72) begin
                len = $urandom_range(1, 4);
                chr = make_char(len);
                for (int k = 0; k < len; k++)
                    add_byte(chr[8*k +: 8], (k == len - 1) && ($urandom_range(0, 19) == 0));
            end else if (pick < 92) begin
                len  = $urandom_range(2, 4);
                chr  = make_char(len);
                keep = $urandom_range(1, len - 1);
                for (int k = 0; k < keep; k++)
                    add_byte(chr[8*k +: 8],
                             (pick < 84) && (k == keep - 1) && ($urandom_range(0, 1) == 0));
                if (pick >= 84)
                    add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end else begin
                add_byte(8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0);
            end
        end

        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        do @(negedge i_clk);
        while (tx_bytes.size() != 0 || s_axis_tvalid || cp_expected.size() != 0);
        repeat (SETTLE) @(negedge i_clk);

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Driver: presents queued bytes, random gaps, at least one drain pause
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : driver
        int         send_gap;
        logic       send_calm;
        logic       held;
        t_text_byte nxt;
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            send_gap  = 0;
            send_calm = 1'b0;
        end else begin
            held = s_axis_tvalid && !s_axis_tready;
            if (s_axis_tvalid && s_axis_tready) begin
                decode_expect(s_axis_tdata, s_axis_tlast);
                if (!quiet_tail && !send_calm && $urandom_range(0, 5) == 0)
                    send_gap = $urandom_range(1, 19);
            end
            if (!held) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_axis_tvalid <= 1'b0;
                end else if (tx_bytes.size() == 0) begin
                    s_axis_tvalid <= 1'b0;
                end else if (tx_bytes[0].wait_drain && results_due != results_seen) begin
                    s_axis_tvalid <= 1'b0;
                end else begin
                    nxt = tx_bytes.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= nxt.data;
                    s_axis_tlast  <= nxt.eot;
                end
            end
            if ($urandom_range(0, 63) == 0)
                send_calm = !send_calm;
            quiet_tail <= (tx_bytes.size() < TAIL_ITEMS);
        end
    end

    // ------------------------------------------------------------------
    // Monitor: checks each result transaction, random back-pressure
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        int                  stall_left;
        logic                recv_calm;
        utf8vd_pkg::t_result want;
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            stall_left = 0;
            recv_calm  = 1'b0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen <= results_seen + 1;
                if (cp_expected.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: unexpected result: code %h status %0d lead %h bad %h",
                                 $realtime, m_axis_tdata[20:0], m_axis_tuser,
                                 m_axis_tdata[28:21], m_axis_tdata[36:29]);
                    mismatches++;
                end else begin
                    want = cp_expected.pop_front();
                    if (m_axis_tdata[20:0]  !== want.code_point     ||
                        m_axis_tuser        !== want.status         ||
                        m_axis_tdata[28:21] !== want.lead_seen      ||
                        m_axis_tdata[36:29] !== want.offending_byte ||
                        m_axis_tdata[39:37] !== 3'b000              ||
                        m_axis_tlast        !== want.last_of_run) begin
                        if (mismatches < 10) begin
                            $display("%0t: mismatch: expected code %h status %0d lead %h bad %h last %b",
                                     $realtime, want.code_point, want.status, want.lead_seen,
                                     want.offending_byte, want.last_of_run);
                            $display("%0t:   got code %h status %0d lead %h bad %h pad %h last %b",
                                     $realtime, m_axis_tdata[20:0], m_axis_tuser,
                                     m_axis_tdata[28:21], m_axis_tdata[36:29],
                                     m_axis_tdata[39:37], m_axis_tlast);
                        end
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else if (!quiet_tail && !recv_calm && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(0, 18);
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
            end
            if ($urandom_range(0, 63) == 0)
                recv_calm = !recv_calm;
        end
    end

    // Watchdog: too long without any transaction on either side
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

endmodule
